// ===== src/stws_pkg.sv =====
package stws_pkg;

  // field widths
  localparam int CODE_W    = 12;
  localparam int AMP_W     = 11;
  localparam int DC_W      = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;

  // q15 datapath
  localparam int TAB_W    = 16;
  localparam int PROD_W   = 28;
  localparam int SUM_W    = 30;
  localparam int CODE_LSB = 15;
  localparam int FRAC_W   = 15;

  localparam logic [CODE_W-1:0] CODE_MAX = '1;
  localparam logic [CODE_W-1:0] CODE_MIN = '0;

  // register reset values
  localparam logic [AMP_W-1:0] SINE_AMP_RST  = 11'd512;
  localparam logic [AMP_W-1:0] SWEEP_AMP_RST = 11'd1024;
  localparam logic [DC_W-1:0]  DC_LEVEL_RST  = 12'd2048;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SINE_AMP  = 2'd0,
    CFG_SWEEP_AMP = 2'd1,
    CFG_DC_LEVEL  = 2'd2
  } cfg_idx_t;

  // live configuration
  typedef struct packed {
    logic [AMP_W-1:0] sine_amplitude;
    logic [AMP_W-1:0] sweep_amplitude;
    logic [DC_W-1:0]  dc_level;
  } cfg_t;

endpackage

// ===== src/stws_if.sv =====
// request word: one tick
interface stws_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

// result word: one dac code
interface stws_out_if;
  logic                        valid;
  logic                        ready;
  logic [stws_pkg::CODE_W-1:0] dac_code;
  logic                        period_end;
  logic                        clipped;

  modport source (output valid, output dac_code, output period_end, output clipped,
                  input ready);
  modport sink (input valid, input dac_code, input period_end, input clipped,
                output ready);
endinterface

// ===== src/stws_front.sv =====
module stws_front #(
  parameter int TABLE_POINTS = 256,
  parameter int PW           = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  stws_in_if.sink       in_ch,
  input  logic          q_full,
  output logic          q_push,
  output logic [PW-1:0] q_phase
);

  localparam logic [PW-1:0] LAST_PHASE = PW'(TABLE_POINTS - 1);

  logic [PW-1:0] phase_r;
  logic [PW-1:0] phase_nxt;
  logic [PW-1:0] cur_phase;

  // accept whenever the queue has room
  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  // restart zeroes the phase before this tick
  always_comb begin
    cur_phase = in_ch.restart ? '0 : phase_r;
    phase_nxt = (cur_phase == LAST_PHASE) ? '0 : cur_phase + PW'(1);
  end

  assign q_phase = cur_phase;

  // phase counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (q_push) begin
      phase_r <= phase_nxt;
    end
  end

endmodule

// ===== src/stws_queue.sv =====
module stws_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output logic [DW-1:0] pop_data
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_pop    = pop && pop_valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (!push && do_pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/stws_back.sv =====
module stws_back #(
  parameter int TABLE_POINTS = 256,
  parameter int SINE_CYCLES  = 4,
  parameter int PW           = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  stws_pkg::cfg_t cfg,
  input  logic           q_valid,
  input  logic [PW-1:0]  q_phase,
  output logic           q_pop,
  stws_out_if.source     out_ch
);

  localparam int TAB_W  = stws_pkg::TAB_W;
  localparam int PROD_W = stws_pkg::PROD_W;
  localparam int SUM_W  = stws_pkg::SUM_W;
  localparam int CODE_W = stws_pkg::CODE_W;
  localparam int LSB    = stws_pkg::CODE_LSB;

  localparam logic [PW-1:0] LAST_PHASE = PW'(TABLE_POINTS - 1);

  // quarter sine polynomial coefficients, q30
  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] SC1     = 64'd1686629713;
  localparam logic [63:0] SC3     = 64'd693598668;
  localparam logic [63:0] SC5     = 64'd85569306;
  localparam logic [63:0] SC7     = 64'd5026995;
  localparam logic [63:0] SC9     = 64'd172272;
  localparam logic [63:0] SC11    = 64'd3864;

  typedef logic signed [TAB_W-1:0] tab_t [TABLE_POINTS];

  // sin(pi/2 * f), f in q30, rounded half up to q15 and capped
  function automatic logic [63:0] quarter_sine(input logic [63:0] f);
    logic [63:0] f2;
    logic [63:0] t;
    logic [63:0] s;
    f2 = (f * f) >> 30;
    t  = SC11;
    t  = SC9 - ((f2 * t) >> 30);
    t  = SC7 - ((f2 * t) >> 30);
    t  = SC5 - ((f2 * t) >> 30);
    t  = SC3 - ((f2 * t) >> 30);
    t  = SC1 - ((f2 * t) >> 30);
    s  = (f * t) >> 30;
    s  = (s + 64'd16384) >> 15;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s;
  endfunction

  // sine sample per phase, already stepped by the cycle count
  function automatic tab_t build_sine_tab();
    tab_t        tab;
    logic [63:0] idx;
    logic [63:0] four;
    logic [63:0] quad;
    logic [63:0] rem;
    logic [63:0] r;
    logic [63:0] f;
    logic [63:0] v;
    for (int k = 0; k < TABLE_POINTS; k++) begin
      idx  = (64'(k) * 64'(SINE_CYCLES)) % TABLE_POINTS;
      four = 64'd4 * idx;
      quad = four / TABLE_POINTS;
      rem  = four % TABLE_POINTS;
      r    = quad[0] ? (64'(TABLE_POINTS) - rem) : rem;
      f    = (r * Q30_ONE) / TABLE_POINTS;
      v    = quarter_sine(f);
      tab[k] = (quad >= 64'd2) ? -TAB_W'(v) : TAB_W'(v);
    end
    return tab;
  endfunction

  // centred triangle per phase, q15 minus one half
  function automatic tab_t build_tri_tab();
    tab_t        tab;
    logic [63:0] t;
    for (int k = 0; k < TABLE_POINTS; k++) begin
      if (2 * k < TABLE_POINTS) begin
        t = (64'(k) << 16) / TABLE_POINTS;
      end else begin
        t = (64'(TABLE_POINTS - k) << 16) / TABLE_POINTS;
      end
      tab[k] = TAB_W'(t - 64'd16384);
    end
    return tab;
  endfunction

  localparam tab_t SINE_TAB = build_sine_tab();
  localparam tab_t TRI_TAB  = build_tri_tab();

  logic                     adv;
  logic                     v1_r, v2_r, out_valid_r;
  logic signed [TAB_W-1:0]  sine_r, tri_r;
  logic                     pend1_r, pend2_r, pend_out_r;
  logic signed [PROD_W-1:0] prod_sine_r, prod_sweep_r;
  logic signed [SUM_W-1:0]  sum;
  logic [CODE_W-1:0]        code_nxt, code_r;
  logic                     clip_nxt, clip_r;

  // whole pipeline moves unless the result is held
  assign adv   = !out_valid_r || out_ch.ready;
  assign q_pop = adv;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= q_valid;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  // table read
  always_ff @(posedge clk) begin
    if (adv) begin
      sine_r  <= SINE_TAB[q_phase];
      tri_r   <= TRI_TAB[q_phase];
      pend1_r <= (q_phase == LAST_PHASE);
    end
  end

  // amplitude scaling
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_sine_r  <= $signed({1'b0, cfg.sine_amplitude}) * sine_r;
      prod_sweep_r <= $signed({1'b0, cfg.sweep_amplitude}) * tri_r;
      pend2_r      <= pend1_r;
    end
  end

  // sum, floor and saturate
  always_comb begin
    sum = $signed(SUM_W'({cfg.dc_level, stws_pkg::FRAC_W'(0)}))
        + SUM_W'(prod_sine_r) + SUM_W'(prod_sweep_r);
    if (sum[SUM_W-1]) begin
      code_nxt = stws_pkg::CODE_MIN;
      clip_nxt = 1'b1;
    end else if (|sum[SUM_W-2:LSB+CODE_W]) begin
      code_nxt = stws_pkg::CODE_MAX;
      clip_nxt = 1'b1;
    end else begin
      code_nxt = sum[LSB+CODE_W-1:LSB];
      clip_nxt = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      code_r     <= code_nxt;
      clip_r     <= clip_nxt;
      pend_out_r <= pend2_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.dac_code   = code_r;
  assign out_ch.clipped    = clip_r;
  assign out_ch.period_end = pend_out_r;

endmodule

// ===== src/sine_triangle_waveform_synth.sv =====
// channel  dir  fields                          width
// in_ch    in   restart                         1
// out_ch   out  dac_code, period_end, clipped   12, 1, 1
// cfg      in   cfg_we, cfg_index, cfg_wdata    1, 2, 12
//
// one word in and one word out per cycle while out_ch is ready; from
// acceptance on, a word passes queue, table read, scaling, sum and saturation
// synchronous reset clears phase, queue, valid bits and the registers to
// their reset values
// a held result freezes the back pipeline; ticks keep being taken until
// the four-entry queue is full
module sine_triangle_waveform_synth #(
  parameter int TABLE_POINTS = 256,
  parameter int SINE_CYCLES  = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  stws_in_if.sink                        in_ch,
  stws_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [stws_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [stws_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  localparam int PW = $clog2(TABLE_POINTS);

  stws_pkg::cfg_t cfg_r;
  logic           q_full, q_push, q_pop, q_valid;
  logic [PW-1:0]  push_phase, pop_phase;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sine_amplitude  <= stws_pkg::SINE_AMP_RST;
      cfg_r.sweep_amplitude <= stws_pkg::SWEEP_AMP_RST;
      cfg_r.dc_level        <= stws_pkg::DC_LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        stws_pkg::CFG_SINE_AMP: begin
          cfg_r.sine_amplitude <= cfg_wdata[stws_pkg::AMP_W-1:0];
        end
        stws_pkg::CFG_SWEEP_AMP: begin
          cfg_r.sweep_amplitude <= cfg_wdata[stws_pkg::AMP_W-1:0];
        end
        stws_pkg::CFG_DC_LEVEL: begin
          cfg_r.dc_level <= cfg_wdata[stws_pkg::DC_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // tick intake and phase
  stws_front #(
    .TABLE_POINTS(TABLE_POINTS),
    .PW(PW)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .q_full(q_full),
    .q_push(q_push),
    .q_phase(push_phase)
  );

  // phase queue
  stws_queue #(
    .DW(PW)
  ) u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(q_push),
    .push_data(push_phase),
    .full(q_full),
    .pop(q_pop),
    .pop_valid(q_valid),
    .pop_data(pop_phase)
  );

  // waveform datapath
  stws_back #(
    .TABLE_POINTS(TABLE_POINTS),
    .SINE_CYCLES(SINE_CYCLES),
    .PW(PW)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .cfg(cfg_r),
    .q_valid(q_valid),
    .q_phase(pop_phase),
    .q_pop(q_pop),
    .out_ch(out_ch)
  );

endmodule

// ===== src/stws_checker.sv =====
module stws_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [stws_pkg::CODE_W-1:0] out_dac_code,
  input logic                        out_clipped
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_dac_code) && $stable(out_clipped))
    else $error("stalled result word changed");

  // clipping only ever lands on a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |->
      out_dac_code == stws_pkg::CODE_MAX || out_dac_code == stws_pkg::CODE_MIN)
    else $error("clipped word off the rails");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

endmodule

bind sine_triangle_waveform_synth stws_checker u_stws_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_dac_code(out_ch.dac_code),
  .out_clipped(out_ch.clipped)
);
